/* sv/bb3_pkg.sv */
// Shared types, constants and helpers for the 3x3 box blur stream.
// Used by every module of the block; no dependencies.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int EFFW_W     = ADDR_W + 1;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int SUM_W      = 12;
  localparam int DIV9_W     = 13;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [DIV9_W-1:0]   DIV9_MUL     = 13'd7282;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    pix_t older;
    pix_t newer;
  } line_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic              emit;
    logic              interior;
    logic              last;
  } pos_t;

  // floor(s / 9) for s up to 9 * 255, by reciprocal multiply
  function automatic logic [7:0] div9(input logic [SUM_W-1:0] s);
    logic [SUM_W+DIV9_W-1:0] prod;
    prod = {{DIV9_W{1'b0}}, s} * {{SUM_W{1'b0}}, DIV9_MUL};
    return prod[23:16];
  endfunction

endpackage

/* sv/bb3_pos.sv */
// Frame geometry registers and input/output position counters.
// Depends on bb3_pkg.
module bb3_pos (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             step,
  output bb3_pkg::pos_t                    pos
);
  import bb3_pkg::*;

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [EFFW_W-1:0]   eff_w;
  logic [HEIGHT_W-1:0] eff_h;

  logic [ADDR_W-1:0]   in_col;
  logic [1:0]          in_row;
  logic [ADDR_W-1:0]   out_col;
  logic [HEIGHT_W-1:0] out_row;

  logic [EFFW_W-1:0]   in_col_inc;
  logic [EFFW_W-1:0]   out_col_inc;
  logic [HEIGHT_W:0]   out_row_inc;
  logic                in_wrap;
  logic                out_wrap;
  logic                emit;
  logic                last;

  always_comb begin
    if (frame_width == '0) begin
      eff_w = EFFW_W'(1);
    end else if (int'(frame_width) > MAX_WIDTH) begin
      eff_w = EFFW_W'(MAX_WIDTH);
    end else begin
      eff_w = EFFW_W'(frame_width);
    end
    eff_h = (frame_height == '0) ? HEIGHT_W'(1) : frame_height;
  end

  assign in_col_inc  = {1'b0, in_col} + EFFW_W'(1);
  assign out_col_inc = {1'b0, out_col} + EFFW_W'(1);
  assign out_row_inc = {1'b0, out_row} + (HEIGHT_W+1)'(1);
  assign in_wrap     = in_col_inc >= eff_w;
  assign out_wrap    = out_col_inc >= eff_w;
  assign emit        = (in_row >= 2'd2) || (in_row >= 2'd1 && in_col != '0);
  assign last        = emit && (out_row_inc == {1'b0, eff_h}) && (out_col_inc == eff_w);

  always_comb begin
    pos.col      = in_col;
    pos.emit     = emit;
    pos.interior = (out_row != '0) && (out_row_inc < {1'b0, eff_h}) &&
                   (out_col != '0) && (out_col_inc < eff_w);
    pos.last     = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_we && (cfg_idx == REG_FRAME_WIDTH || cfg_idx == REG_FRAME_HEIGHT))) begin
      in_col  <= '0;
      in_row  <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (step) begin
      if (last) begin
        in_col  <= '0;
        in_row  <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (in_wrap) begin
          in_col <= '0;
          if (in_row != 2'd2) begin
            in_row <= in_row + 2'd1;
          end
        end else begin
          in_col <= in_col_inc[ADDR_W-1:0];
        end
        if (emit) begin
          if (out_wrap) begin
            out_col <= '0;
            out_row <= out_row_inc[HEIGHT_W-1:0];
          end else begin
            out_col <= out_col_inc[ADDR_W-1:0];
          end
        end
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst) {1'b0, in_col} < eff_w && {1'b0, out_col} < eff_w)
    else $error("bb3_pos: column counter beyond frame width");
  assert property (@(posedge clk) disable iff (rst) out_row < eff_h)
    else $error("bb3_pos: output row beyond frame height");
`endif

endmodule

/* sv/bb3_line_mem.sv */
// Two-row line store, one entry per column holding the older and newer row.
// Registered read with write-to-read forwarding. Depends on bb3_pkg.
module bb3_line_mem (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [bb3_pkg::ADDR_W-1:0] rd_addr,
  output bb3_pkg::line_t             rd_data,
  input  logic                       wr_en,
  input  logic [bb3_pkg::ADDR_W-1:0] wr_addr,
  input  bb3_pkg::line_t             wr_data
);
  import bb3_pkg::*;

  line_t mem [MAX_WIDTH];
  line_t rd_q;
  line_t fwd_q;
  logic  fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q  <= mem[rd_addr];
      fwd_q <= wr_data;
      fwd   <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd ? fwd_q : rd_q;

endmodule

/* sv/bb3_window.sv */
// 3x3 pixel window with registered per-channel sums and center pixel.
// Depends on bb3_pkg.
module bb3_window (
  input  logic          clk,
  input  logic          rst,
  input  logic          shift,
  input  bb3_pkg::pix_t col_top,
  input  bb3_pkg::pix_t col_mid,
  input  bb3_pkg::pix_t col_bot,
  output bb3_pkg::sum_t sum,
  output bb3_pkg::pix_t center
);
  import bb3_pkg::*;

  pix_t cells [9];
  pix_t nxt [9];
  sum_t sum_next;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      nxt[k] = cells[k+3];
    end
    nxt[6] = col_top;
    nxt[7] = col_mid;
    nxt[8] = col_bot;
    sum_next = '0;
    for (int k = 0; k < 9; k++) begin
      sum_next.red   = sum_next.red   + SUM_W'(nxt[k].red);
      sum_next.green = sum_next.green + SUM_W'(nxt[k].green);
      sum_next.blue  = sum_next.blue  + SUM_W'(nxt[k].blue);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        cells[k] <= '0;
      end
    end else if (shift) begin
      for (int k = 0; k < 9; k++) begin
        cells[k] <= nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sum    <= sum_next;
      center <= nxt[4];
    end
  end

endmodule

/* sv/box_blur_3x3_stream.sv */
// 3x3 box blur over an RGB raster stream with two line stores.
// Throughput: one request per cycle unless the output stalls with the pipeline full;
// the stream as a whole lags by frame_width + 1 requests.
// The line-store read, the window sum and the divide by 9 each take one register stage.
// Reset: width 640, height 480, positions and window cleared, output empty;
// the line stores are not cleared and the block is ready at once.
module box_blur_3x3_stream (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             mode,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_red,
  output logic [7:0]                       out_green,
  output logic [7:0]                       out_blue,
  output logic                             frame_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bb3_pkg::*;

  pos_t  pos;
  pix_t  pix_in;
  logic  accept;

  logic  v1;
  pix_t  pix1;
  pos_t  pos1;
  line_t rd;
  line_t wr;

  logic  v2;
  logic  int2;
  logic  last2;
  sum_t  sum2;
  pix_t  center2;

  logic  out_free;
  logic  s2_free;
  logic  adv1;

  assign cfg_ready = !rst;
  assign out_free  = !out_valid || out_ready;
  assign s2_free   = !v2 || out_free;
  assign adv1      = v1 && s2_free;
  assign in_ready  = !rst && (!v1 || s2_free);
  assign accept    = in_valid && in_ready;
  assign pix_in    = mode ? '0 : pix_t'{red: in_red, green: in_green, blue: in_blue};

  bb3_pos u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .step      (accept),
    .pos       (pos)
  );

  assign wr.older = rd.newer;
  assign wr.newer = pix1;

  bb3_line_mem u_line (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (pos.col),
    .rd_data (rd),
    .wr_en   (adv1),
    .wr_addr (pos1.col),
    .wr_data (wr)
  );

  bb3_window u_win (
    .clk     (clk),
    .rst     (rst),
    .shift   (adv1),
    .col_top (rd.older),
    .col_mid (rd.newer),
    .col_bot (pix1),
    .sum     (sum2),
    .center  (center2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (in_ready) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix1 <= pix_in;
      pos1 <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (s2_free) begin
      v2 <= adv1 && pos1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      int2  <= pos1.interior;
      last2 <= pos1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v2) begin
      out_red    <= int2 ? div9(sum2.red)   : center2.red;
      out_green  <= int2 ? div9(sum2.green) : center2.green;
      out_blue   <= int2 ? div9(sum2.blue)  : center2.blue;
      frame_last <= last2;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && out_valid && !out_ready) |-> !in_ready)
    else $error("box_blur_3x3_stream: request taken with full pipeline stalled");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !v2) |=> !out_valid)
    else $error("box_blur_3x3_stream: result shown without a pending window stage");
`endif

endmodule

/* tb/sv/testbench.sv */
// Self-checking bench for box_blur_3x3_stream: random RGB frames, flushes and geometry changes.
// A window tracker predicts each blurred or passed-through pixel and frame_last bit.
// Depends on bb3_pkg and the box_blur_3x3_stream RTL only.
module testbench;
  import bb3_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 420;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 24;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_CAP    = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    pix_t px;
    logic last;
  } blur_out_t;

  class blur_ledger;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    pix_t                older_row [MAX_WIDTH];
    pix_t                newer_row [MAX_WIDTH];
    pix_t                win [9];
    int unsigned         in_col, in_row, out_col, out_row;
    blur_out_t           owed_pixels [$];
    int unsigned         requests, results, frame_ends, reg_writes, errors;

    function void clear_positions();
      in_col = 0;
      in_row = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void reset();
      width_reg = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      clear_positions();
      owed_pixels.delete();
      requests = 0;
      results = 0;
      frame_ends = 0;
      reg_writes = 0;
      errors = 0;
    endfunction

    function int unsigned width_now();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned height_now();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = data[WIDTH_W-1:0];
        clear_positions();
      end else if (idx == REG_FRAME_HEIGHT) begin
        height_reg = data[HEIGHT_W-1:0];
        clear_positions();
      end
    endfunction

    function void take_request(logic flush, pix_t px);
      int unsigned w, h, x, sr, sg, sbl;
      pix_t        cur, up2, up1;
      blur_out_t   res;
      bit          emit;
      w = width_now();
      h = height_now();
      requests++;
      cur = flush ? pix_t'('0) : px;
      x = (in_col >= w) ? 0 : in_col;
      up2 = older_row[x];
      up1 = newer_row[x];
      older_row[x] = up1;
      newer_row[x] = cur;
      for (int k = 0; k < 6; k++) win[k] = win[k + 3];
      win[6] = up2;
      win[7] = up1;
      win[8] = cur;
      emit = (in_row >= 2) || (in_row >= 1 && x >= 1);
      in_col = x + 1;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (!emit) return;
      if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
        sr = 0;
        sg = 0;
        sbl = 0;
        foreach (win[k]) begin
          sr += win[k].red;
          sg += win[k].green;
          sbl += win[k].blue;
        end
        res.px = pix_t'({8'(sr / 9), 8'(sg / 9), 8'(sbl / 9)});
      end else begin
        res.px = win[4];
      end
      res.last = (out_row + 1 == h) && (out_col + 1 == w);
      owed_pixels.push_back(res);
      if (res.last) begin
        clear_positions();
      end else begin
        out_col++;
        if (out_col >= w) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void match_result(blur_out_t got);
      blur_out_t want;
      results++;
      if (got.last === 1'b1) frame_ends++;
      if (owed_pixels.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, got r=%0d g=%0d b=%0d last=%0b",
                   $time, got.px.red, got.px.green, got.px.blue, got.last);
        return;
      end
      want = owed_pixels.pop_front();
      compare("out_red", want.px.red, got.px.red);
      compare("out_green", want.px.green, got.px.green);
      compare("out_blue", want.px.blue, got.px.blue);
      compare("frame_last", 8'(want.last), 8'(got.last));
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  mode;
  logic [7:0]            in_red;
  logic [7:0]            in_green;
  logic [7:0]            in_blue;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_red;
  logic [7:0]            out_green;
  logic [7:0]            out_blue;
  logic                  frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  blur_ledger  ledger;
  bit          hold_off_req = 1'b0;
  int unsigned hold_offs = 0;
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;

  box_blur_3x3_stream u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .in_red     (in_red),
    .in_green   (in_green),
    .in_blue    (in_blue),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .frame_last (frame_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) ledger.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) ledger.take_request(mode, pix_t'({in_red, in_green, in_blue}));
      if (out_valid && out_ready)
        ledger.match_result(blur_out_t'({out_red, out_green, out_blue, frame_last}));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, ledger.owed_pixels.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : rx_stall
    int unsigned style;
    int unsigned style_left;
    int unsigned tick;
    style = 0;
    style_left = 0;
    tick = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end
      if (style_left == 0) begin
        style = $urandom_range(0, 3);
        style_left = $urandom_range(50, 300);
      end
      style_left--;
      tick++;
      case (style)
        0: out_ready = 1'b1;
        1: out_ready = ($urandom_range(0, 3) != 0);
        2: out_ready = ($urandom_range(0, 1) != 0);
        default: out_ready = ((tick % 5) < 3);
      endcase
    end
  end

  function automatic pix_t rand_pix();
    logic [7:0] c [3];
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 5))
        0: c[k] = 8'h00;
        1: c[k] = 8'hFF;
        default: c[k] = 8'($urandom_range(0, 255));
      endcase
    end
    return pix_t'({c[0], c[1], c[2]});
  endfunction

  task automatic push_item(input logic flush, input pix_t px);
    int unsigned gap;
    @(negedge clk);
    in_valid = 1'b1;
    mode = flush;
    in_red = px.red;
    in_green = px.green;
    in_blue = px.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drop valid, drain owed results, then let in-flight requests leave the pipe
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (ledger.owed_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    settle();
    set_register(REG_FRAME_WIDTH, w);
    set_register(REG_FRAME_HEIGHT, h);
  endtask

  task automatic send_frame(input int unsigned flush_odds, input int unsigned pixel_odds);
    int unsigned w;
    int unsigned h;
    w = ledger.width_now();
    h = ledger.height_now();
    repeat (w * h) push_item(flush_odds > 0 && $urandom_range(1, flush_odds) == 1, rand_pix());
    repeat (w + 1) push_item(!(pixel_odds > 0 && $urandom_range(1, pixel_odds) == 1), rand_pix());
  endtask

  initial begin
    int unsigned start;
    int unsigned w;
    int unsigned h;
    ledger = new();
    ledger.reset();
    rst = 1'b1;
    in_valid = 1'b0;
    mode = 1'b0;
    in_red = 8'h00;
    in_green = 8'h00;
    in_blue = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry: nothing may come out this early
    push_item(1'b0, '1);
    push_item(1'b1, '0);
    push_item(1'b0, pix_t'(24'h00FF00));

    // full-scale interior sum, then a black pixel and a white one where flushes are due
    set_geometry(12'd3, 12'd3);
    set_register(REG_SPARE_A, 12'hFFF);
    repeat (9) push_item(1'b0, '1);
    push_item(1'b1, '1);
    push_item(1'b0, '0);
    push_item(1'b0, '1);
    push_item(1'b1, '0);

    // zero width and height act as one
    set_geometry(12'd0, 12'd0);
    push_item(1'b0, pix_t'(24'h807F01));
    push_item(1'b1, '0);
    push_item(1'b1, '1);

    // small frame with a flush among the pixels
    set_geometry(12'd2, 12'd2);
    set_register(REG_SPARE_B, 12'h5A5);
    push_item(1'b0, '1);
    push_item(1'b1, '1);
    push_item(1'b0, pix_t'(24'h0FF05A));
    push_item(1'b0, pix_t'(24'hA50FF0));
    push_item(1'b0, pix_t'(24'h123456));
    push_item(1'b1, '0);
    push_item(1'b1, '0);

    // oversized width clamps to the line store depth
    set_geometry(12'hFFF, 12'hFFF);
    repeat (MAX_WIDTH + 41) push_item($urandom_range(0, 7) == 0, rand_pix());

    // tall one-column frame with a long receiver hold-off
    set_geometry(12'd1, 12'd40);
    hold_off_req = 1'b1;
    send_frame(0, 2);

    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2);
      else if ($urandom_range(0, 7) == 0) w = $urandom_range(17, 64);
      else w = $urandom_range(3, 16);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      set_geometry(12'(w), 12'(h));
      if ($urandom_range(0, 9) == 0)
        set_register($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 12'($urandom));
      repeat ($urandom_range(1, 2)) begin
        case ($urandom_range(0, 7))
          0: repeat ($urandom_range(1, 40)) push_item($urandom_range(0, 1), rand_pix());
          1, 2, 3: send_frame(12, 3);
          default: send_frame(0, 0);
        endcase
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Run covered %0d requests and %0d register writes; %0d results checked, %0d frame ends",
             ledger.requests, ledger.reg_writes, ledger.results, ledger.frame_ends);
    $display("Geometries from 1x1 up to the 1024-column clamp, %0d receiver hold-off(s), %0d errors",
             hold_offs, ledger.errors);
    if (ledger.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/bb3_pkg.sv
sv/bb3_pos.sv
sv/bb3_line_mem.sv
sv/bb3_window.sv
sv/box_blur_3x3_stream.sv
tb/sv/testbench.sv
